// ----- hdl/lrupo_pkg.sv -----
// Shared types and codes for the LRU page order tracker.
`timescale 1ns / 1ps
`default_nettype none

package lrupo_pkg;

  // Operation codes on the input word
  localparam logic OP_TOUCH = 1'b0;
  localparam logic OP_EVICT = 1'b1;

  // Result status codes
  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_EMPTY      = 2'd1;
  localparam logic [1:0] STATUS_FULL_DROP  = 2'd2;

  // Field widths of the channel words
  localparam int unsigned PAGE_FIELD_BITS = 12;
  localparam int unsigned STATUS_BITS     = 2;

  // Command broadcast to every cell for the word being accepted
  typedef struct packed {
    logic do_evict;   // shift whole chain down by one
    logic do_move;    // move hit page to the most-recent end
    logic do_append;  // write page into first free cell
  } cell_cmd_t;

endpackage

`default_nettype wire

// ----- hdl/lrupo_cell.sv -----
// One slot of the LRU chain: holds a page, compares it, shifts from its upper neighbor.
`timescale 1ns / 1ps
`default_nettype none

module lrupo_cell
  import lrupo_pkg::*;
#(
  parameter int unsigned PAGE_BITS = 12
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cell_cmd_t            cmd_i,
  input  wire logic [PAGE_BITS-1:0] page_i,
  input  wire logic [PAGE_BITS-1:0] up_page_i,
  input  wire logic                 up_valid_i,
  input  wire logic                 dn_valid_i,
  input  wire logic                 found_i,
  output logic                      found_o,
  output logic [PAGE_BITS-1:0]      page_o,
  output logic                      valid_o
);

  logic [PAGE_BITS-1:0] page_q, page_d;
  logic                 valid_q, valid_d;
  logic                 match;
  logic                 last;

  // Compare against the touched page; pass the hit marker upward
  assign match   = valid_q && (page_q == page_i);
  assign found_o = found_i | match;
  // Most-recent occupied slot
  assign last    = valid_q && !up_valid_i;

  // Next slot contents
  always_comb begin
    page_d  = page_q;
    valid_d = valid_q;
    if (cmd_i.do_evict) begin
      page_d  = up_page_i;
      valid_d = up_valid_i;
    end else if (cmd_i.do_move) begin
      if (found_o && valid_q) begin
        page_d = last ? page_i : up_page_i;
      end
    end else if (cmd_i.do_append) begin
      if (!valid_q && dn_valid_i) begin
        page_d  = page_i;
        valid_d = 1'b1;
      end
    end
  end

  // Occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Page number; only read while the slot is occupied
  always_ff @(posedge clk_i) begin
    page_q <= page_d;
  end

  assign page_o  = page_q;
  assign valid_o = valid_q;

endmodule

`default_nettype wire

// ----- hdl/lru_page_order_tracker.sv -----
// Top level of the LRU page order tracker: cell chain plus result register.
//
//   channel | direction | handshake                  | word
//   --------+-----------+----------------------------+------------------------------
//   in      | input     | in_valid_i / in_ready_o    | operation_i, page_number_i
//   out     | output    | out_valid_o / out_ready_i  | victim_page_o, status_o
//
// One word per cycle unless stalled: compare, hit marker ripple and shift all
// finish in the cycle the word is taken; the result appears in the output
// register in the next cycle. in_ready_o is low only while a result waits and
// out_ready_i is low. Reset empties the store at once; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module lru_page_order_tracker
  import lrupo_pkg::*;
#(
  parameter int unsigned SLOTS     = 32,
  parameter int unsigned PAGE_BITS = 12
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic                       operation_i,
  input  wire logic [PAGE_FIELD_BITS-1:0] page_number_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output logic [PAGE_FIELD_BITS-1:0]      victim_page_o,
  output logic [STATUS_BITS-1:0]          status_o
);

  logic                            in_acc;
  logic [PAGE_BITS+PAGE_FIELD_BITS-1:0] page_ext;
  logic [PAGE_BITS-1:0]            page_w;
  logic [PAGE_BITS-1:0]            cell_page [SLOTS];
  logic [SLOTS-1:0]                valid_vec;
  logic [SLOTS:0]                  found;
  logic                            hit;
  logic                            empty;
  logic                            full;
  cell_cmd_t                       cmd;
  logic [PAGE_BITS+PAGE_FIELD_BITS-1:0] victim_ext;

  logic                            out_valid_q;
  logic [PAGE_FIELD_BITS-1:0]      victim_q, victim_d;
  logic [STATUS_BITS-1:0]          status_q, status_d;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  // Fit the page field to the stored width
  assign page_ext = {{PAGE_BITS{1'b0}}, page_number_i};
  assign page_w   = page_ext[PAGE_BITS-1:0];

  assign empty = !valid_vec[0];
  assign full  = valid_vec[SLOTS-1];
  assign hit   = found[SLOTS];
  assign found[0] = 1'b0;

  // Command for the chain
  always_comb begin
    cmd.do_evict  = in_acc && (operation_i == OP_EVICT) && !empty;
    cmd.do_move   = in_acc && (operation_i == OP_TOUCH) && hit;
    cmd.do_append = in_acc && (operation_i == OP_TOUCH) && !hit && !full;
  end

  // Cell chain, slot 0 least recent
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    logic [PAGE_BITS-1:0] up_page;
    logic                 up_valid;
    logic                 dn_valid;

    if (i == SLOTS - 1) begin : g_top
      assign up_page  = '0;
      assign up_valid = 1'b0;
    end else begin : g_mid
      assign up_page  = cell_page[i+1];
      assign up_valid = valid_vec[i+1];
    end

    if (i == 0) begin : g_bot
      assign dn_valid = 1'b1;
    end else begin : g_up
      assign dn_valid = valid_vec[i-1];
    end

    lrupo_cell #(
      .PAGE_BITS(PAGE_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cmd_i      (cmd),
      .page_i     (page_w),
      .up_page_i  (up_page),
      .up_valid_i (up_valid),
      .dn_valid_i (dn_valid),
      .found_i    (found[i]),
      .found_o    (found[i+1]),
      .page_o     (cell_page[i]),
      .valid_o    (valid_vec[i])
    );
  end

  // Result for the accepted word
  assign victim_ext = {{PAGE_FIELD_BITS{1'b0}}, cell_page[0]};

  always_comb begin
    victim_d = '0;
    status_d = STATUS_OK;
    if (operation_i == OP_EVICT) begin
      if (empty) begin
        status_d = STATUS_EMPTY;
      end else begin
        victim_d = victim_ext[PAGE_FIELD_BITS-1:0];
      end
    end else if (!hit && full) begin
      status_d = STATUS_FULL_DROP;
    end
  end

  // Output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_acc;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      victim_q <= victim_d;
      status_q <= status_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign victim_page_o = victim_q;
  assign status_o      = status_q;

  // Occupied slots always form a prefix of the chain
  a_valid_prefix : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_vec[SLOTS-1:1] & ~valid_vec[SLOTS-2:0]) == '0)
    else $error("occupied slots are not a prefix");

  // An evict on a non-empty store frees exactly one slot
  a_evict_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.do_evict |=> $countones(valid_vec) == $past($countones(valid_vec)) - 1)
    else $error("evict did not free exactly one slot");

  // A touch that hits keeps the occupancy unchanged
  a_move_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.do_move |=> $stable(valid_vec))
    else $error("touch hit changed occupancy");

  // An append takes exactly one more slot
  a_append_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.do_append |=> $countones(valid_vec) == $past($countones(valid_vec)) + 1)
    else $error("append did not take exactly one slot");

endmodule

`default_nettype wire
